### hw/rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and codes of the block buffer cache tag store.
// ----------------------------------------------------------------------------
package bbc_pkg;

	localparam int HOME_W = 6;

	localparam logic [1:0] OP_READ    = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_PIN     = 2'd2;
	localparam logic [1:0] OP_UNPIN   = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_UNDER  = 2'd2;

	typedef struct packed {
		logic [7:0]        dev;
		logic [31:0]       blk;
		logic [7:0]        refc;
		logic [31:0]       last;
		logic              cv;
		logic [HOME_W-1:0] home;
	} entry_rec_t;

endpackage

### hw/rtl/bbc_req_if.sv
// ----------------------------------------------------------------------------
// bbc_req_if
// Request channel: valid/ready with the request fields.
// ----------------------------------------------------------------------------
interface bbc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  device;
	logic [31:0] block_number;
	logic [4:0]  slot;
	logic [31:0] now_tick;

	modport source (output valid, op, device, block_number, slot, now_tick, input ready);
	modport sink (input valid, op, device, block_number, slot, now_tick, output ready);
endinterface

### hw/rtl/bbc_rsp_if.sv
// ----------------------------------------------------------------------------
// bbc_rsp_if
// Response channel: valid/ready with the result fields.
// ----------------------------------------------------------------------------
interface bbc_rsp_if;
	logic       valid;
	logic       ready;
	logic [4:0] entry;
	logic       hit;
	logic       must_fetch;
	logic [1:0] status;

	modport source (output valid, entry, hit, must_fetch, status, input ready);
	modport sink (input valid, entry, hit, must_fetch, status, output ready);
endinterface

### hw/rtl/bbc_mod.sv
// ----------------------------------------------------------------------------
// bbc_mod
// Block number modulo bucket count, four bits per cycle.
// ----------------------------------------------------------------------------
module bbc_mod import bbc_pkg::*; #(
	parameter int BUCKETS = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [31:0]       value,
	output logic              done,
	output logic [HOME_W-1:0] rem
);
	localparam int RW = $clog2(BUCKETS) + 1;

	logic [31:0]   val_q;
	logic [RW-1:0] rem_q;
	logic [2:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [RW-1:0] rem_nx;

	always_comb begin
		logic [RW:0] t;
		rem_nx = rem_q;
		for (int j = 0; j < 4; j++) begin
			t = {rem_nx, val_q[31-j]};
			if (t >= (RW+1)'(BUCKETS))
				t = t - (RW+1)'(BUCKETS);
			rem_nx = t[RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
		end else if (busy_q) begin
			val_q <= val_q << 4;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign rem  = HOME_W'(rem_q);
endmodule

### hw/rtl/bbc_tag_mem.sv
// ----------------------------------------------------------------------------
// bbc_tag_mem
// Entry record memory, one read and one write port, registered read.
// ----------------------------------------------------------------------------
module bbc_tag_mem import bbc_pkg::*; #(
	parameter int ENTRIES = 32,
	parameter int IW      = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	output entry_rec_t    rd_data,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  entry_rec_t    wr_data
);
	entry_rec_t         mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;
	entry_rec_t         rdat_s1;
	logic               rvld_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rdat_s1 <= mem[rd_addr];
	end

	// entries never written read as the reset record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rvld_s1 <= vld_q[rd_addr];
		end
	end

	assign rd_data = rvld_s1 ? rdat_s1 : '0;
endmodule

### hw/rtl/block_buffer_cache_lru.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_lru
// Tag store of a disk block cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One request at a time; the request side is ready only while idle. A read
// first computes the bucket remainder, then makes one pass over the record
// memory, one entry per cycle, which finds the tag match and the victim in
// the same pass. Then come a resolve step and a write-back step that posts
// the result. Release, pin and unpin do a read, then modify, then
// write-back; with a slot out of range they go straight to posting the
// result with no write. A new request is taken the cycle after the result
// is posted. The finished result waits in an output register. While it is
// not taken, the next result holds in write-back and the input stalls.
module block_buffer_cache_lru import bbc_pkg::*; #(
	parameter int ENTRIES = 32,
	parameter int BUCKETS = 13
) (
	input  logic clk,
	input  logic arst_n,
	bbc_req_if.sink   req,
	bbc_rsp_if.source rsp
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_MOD     = 3'd1;
	localparam logic [2:0] S_SCAN    = 3'd2;
	localparam logic [2:0] S_SLOT    = 3'd3;
	localparam logic [2:0] S_RESOLVE = 3'd4;
	localparam logic [2:0] S_EMIT    = 3'd5;

	logic [2:0]        state_q;
	logic [1:0]        op_q;
	logic [7:0]        dev_q;
	logic [31:0]       blk_q;
	logic [31:0]       now_q;
	logic [HOME_W-1:0] want_q;
	logic [IW:0]       cnt_q;
	logic              rv_s1;
	logic [IW-1:0]     ridx_s1;

	logic              hit_found_q;
	logic [IW-1:0]     hit_idx_q;
	entry_rec_t        hit_rec_q;
	logic              vic_found_q;
	logic [IW-1:0]     vic_idx_q;
	logic [HOME_W-1:0] vic_d_q;
	logic [31:0]       vic_last_q;

	logic [4:0]        res_entry_q;
	logic              res_hit_q;
	logic              res_fetch_q;
	logic [1:0]        res_status_q;
	logic              wr_pend_q;
	logic [IW-1:0]     wr_idx_q;
	entry_rec_t        wr_rec_q;

	logic              rsp_valid_q;
	logic [4:0]        rsp_entry_q;
	logic              rsp_hit_q;
	logic              rsp_fetch_q;
	logic [1:0]        rsp_status_q;

	logic              acc;
	logic [8:0]        slot9;
	logic              slot_ok;
	logic              mod_start;
	logic              mod_done;
	logic [HOME_W-1:0] mod_rem;
	logic              rd_en;
	logic [IW-1:0]     rd_addr;
	entry_rec_t        rd_data;
	logic              emit_go;
	logic              match;
	logic [HOME_W-1:0] bkt_dist;
	logic              better;
	entry_rec_t        slot_rec;
	logic [1:0]        slot_st;
	entry_rec_t        hit_rec;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign slot9     = 9'(req.slot);
	assign slot_ok   = slot9 < 9'(ENTRIES);
	assign mod_start = acc && (req.op == OP_READ);
	assign emit_go   = (state_q == S_EMIT) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cnt_q[IW-1:0];
		if (acc && req.op != OP_READ && slot_ok) begin
			rd_en   = 1'b1;
			rd_addr = slot9[IW-1:0];
		end else if (state_q == S_SCAN && cnt_q < (IW+1)'(ENTRIES)) begin
			rd_en = 1'b1;
		end
	end

	assign match    = (rd_data.dev == dev_q) && (rd_data.blk == blk_q);
	assign bkt_dist = (rd_data.home >= want_q) ? rd_data.home - want_q
	                : HOME_W'(7'(rd_data.home) + 7'(BUCKETS) - 7'(want_q));
	assign better   = !vic_found_q || bkt_dist < vic_d_q
	                || (bkt_dist == vic_d_q && rd_data.last < vic_last_q);

	// updated records for the slot ops and for a hit
	always_comb begin
		slot_rec = rd_data;
		slot_st  = ST_OK;
		if (op_q == OP_PIN) begin
			if (rd_data.refc != 8'hff)
				slot_rec.refc = rd_data.refc + 8'd1;
		end else begin
			if (rd_data.refc == 8'd0)
				slot_st = ST_UNDER;
			else
				slot_rec.refc = rd_data.refc - 8'd1;
			if (op_q == OP_RELEASE)
				slot_rec.last = now_q;
		end
		hit_rec = hit_rec_q;
		if (hit_rec_q.refc != 8'hff)
			hit_rec.refc = hit_rec_q.refc + 8'd1;
		hit_rec.last = now_q;
		hit_rec.cv   = 1'b1;
	end

	bbc_mod #(.BUCKETS(BUCKETS)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .value(req.block_number),
		.done(mod_done), .rem(mod_rem)
	);

	bbc_tag_mem #(.ENTRIES(ENTRIES), .IW(IW)) u_mem (
		.clk(clk), .arst_n(arst_n), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
		.wr_en(emit_go && wr_pend_q), .wr_addr(wr_idx_q), .wr_data(wr_rec_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rv_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
			hit_found_q <= 1'b0;
			vic_found_q <= 1'b0;
			wr_pend_q   <= 1'b0;
		end else begin
			rv_s1 <= rd_en;
			if (emit_go)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (req.op == OP_READ)
							state_q <= S_MOD;
						else if (slot_ok)
							state_q <= S_SLOT;
						else begin
							wr_pend_q <= 1'b0;
							state_q   <= S_EMIT;
						end
					end
				end
				S_MOD: begin
					if (mod_done) begin
						cnt_q       <= '0;
						hit_found_q <= 1'b0;
						vic_found_q <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_en)
						cnt_q <= cnt_q + (IW+1)'(1);
					if (rv_s1) begin
						if (match && !hit_found_q)
							hit_found_q <= 1'b1;
						if (rd_data.refc == 8'd0 && better)
							vic_found_q <= 1'b1;
						if (ridx_s1 == IW'(ENTRIES - 1))
							state_q <= S_RESOLVE;
					end
				end
				S_SLOT: begin
					wr_pend_q <= 1'b1;
					state_q   <= S_EMIT;
				end
				S_RESOLVE: begin
					wr_pend_q <= hit_found_q || vic_found_q;
					state_q   <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= rd_addr;
		if (acc) begin
			op_q        <= req.op;
			dev_q       <= req.device;
			blk_q       <= req.block_number;
			now_q       <= req.now_tick;
			wr_idx_q    <= slot9[IW-1:0];
			res_entry_q  <= req.slot;
			res_hit_q    <= 1'b0;
			res_fetch_q  <= 1'b0;
			res_status_q <= ST_NOFREE;
		end
		if (mod_done)
			want_q <= mod_rem;
		if (state_q == S_SCAN && rv_s1) begin
			if (match && !hit_found_q) begin
				hit_idx_q <= ridx_s1;
				hit_rec_q <= rd_data;
			end
			if (rd_data.refc == 8'd0 && better) begin
				vic_idx_q  <= ridx_s1;
				vic_d_q    <= bkt_dist;
				vic_last_q <= rd_data.last;
			end
		end
		if (state_q == S_SLOT) begin
			wr_rec_q     <= slot_rec;
			res_status_q <= slot_st;
		end
		if (state_q == S_RESOLVE) begin
			priority if (hit_found_q) begin
				wr_idx_q      <= hit_idx_q;
				wr_rec_q      <= hit_rec;
				res_entry_q   <= 5'(hit_idx_q);
				res_hit_q     <= 1'b1;
				res_fetch_q   <= !hit_rec_q.cv;
				res_status_q  <= ST_OK;
			end else if (vic_found_q) begin
				wr_idx_q     <= vic_idx_q;
				wr_rec_q     <= '{dev: dev_q, blk: blk_q, refc: 8'd1, last: now_q,
				                  cv: 1'b1, home: want_q};
				res_entry_q  <= 5'(vic_idx_q);
				res_hit_q    <= 1'b0;
				res_fetch_q  <= 1'b1;
				res_status_q <= ST_OK;
			end else begin
				res_entry_q  <= 5'd0;
				res_hit_q    <= 1'b0;
				res_fetch_q  <= 1'b0;
				res_status_q <= ST_NOFREE;
			end
		end
		if (emit_go) begin
			rsp_entry_q  <= res_entry_q;
			rsp_hit_q    <= res_hit_q;
			rsp_fetch_q  <= res_fetch_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.entry      = rsp_entry_q;
	assign rsp.hit        = rsp_hit_q;
	assign rsp.must_fetch = rsp_fetch_q;
	assign rsp.status     = rsp_status_q;
endmodule
